/* rtl/conv_forward_valid_assert.svh */
// assertion macros shared by the checker
// no dependencies
`ifndef CONV_FORWARD_VALID_ASSERT_SVH
`define CONV_FORWARD_VALID_ASSERT_SVH
`define CFV_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: check failed");
`define CFV_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: check failed");
`endif

/* rtl/cfv_pkg.sv */
// shared types and constants for the convolution block
// no dependencies
`timescale 1ns / 1ps
package cfv_pkg;
  localparam int unsigned MaxInMaps  = 16;
  localparam int unsigned MaxOutMaps = 16;
  localparam int unsigned MaxSide    = 64;
  localparam int unsigned MaxWindow  = 8;
  localparam int unsigned ImW  = $clog2(MaxInMaps);
  localparam int unsigned OmW  = $clog2(MaxOutMaps);
  localparam int unsigned SdW  = $clog2(MaxSide);
  localparam int unsigned WnW  = $clog2(MaxWindow);
  localparam int unsigned WAddrW = OmW + ImW + 2 * WnW;
  localparam int unsigned SAddrW = ImW + 2 * SdW;
  localparam int unsigned QDepth = 4;

  typedef enum logic [1:0] {
    OpWeight = 2'd0, OpBias = 2'd1, OpSample = 2'd2, OpCompute = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegInWidth = 3'd0, RegInHeight = 3'd1, RegWinWidth = 3'd2,
    RegWinHeight = 3'd3, RegInMaps = 3'd4, RegOutMaps = 3'd5
  } reg_e;

  // classified request handed from front to back
  typedef struct packed {
    logic            bad;
    logic [OmW-1:0]  om;
    logic [SdW-1:0]  py;
    logic [SdW-1:0]  px;
    logic [WnW:0]    ww;
    logic [WnW:0]    wh;
    logic [ImW:0]    nin;
  } job_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

/* rtl/cfv_front.sv */
// front end: config registers, store write decode, request classification
// depends on cfv_pkg
`timescale 1ns / 1ps
module cfv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                acc_i,
  input  logic [1:0]          operation_i,
  input  logic [3:0]          out_map_i,
  input  logic [5:0]          pos_y_i,
  input  logic [5:0]          pos_x_i,
  output logic                wr_w_o,
  output logic                wr_b_o,
  output logic                wr_s_o,
  output logic                job_v_o,
  output cfv_pkg::job_t       job_o
);
  logic [6:0] iw_q, ih_q;
  logic [3:0] ww_q, wh_q;
  logic [4:0] nin_q, nout_q;
  logic [6:0] iw, ih;
  logic [3:0] ww, wh;
  logic [4:0] nin, nout;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= 7'd64; ih_q <= 7'd64; ww_q <= 4'd3; wh_q <= 4'd3;
      nin_q <= 5'd1; nout_q <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfv_pkg::RegInWidth:   iw_q   <= cfg_data[6:0];
        cfv_pkg::RegInHeight:  ih_q   <= cfg_data[6:0];
        cfv_pkg::RegWinWidth:  ww_q   <= cfg_data[3:0];
        cfv_pkg::RegWinHeight: wh_q   <= cfg_data[3:0];
        cfv_pkg::RegInMaps:    nin_q  <= cfg_data[4:0];
        cfv_pkg::RegOutMaps:   nout_q <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp into legal ranges
  always_comb begin
    iw = (iw_q == 7'd0) ? 7'd1 : ((iw_q > 7'd64) ? 7'd64 : iw_q);
    ih = (ih_q == 7'd0) ? 7'd1 : ((ih_q > 7'd64) ? 7'd64 : ih_q);
    ww = (ww_q == 4'd0) ? 4'd1 : ((ww_q > 4'd8) ? 4'd8 : ww_q);
    wh = (wh_q == 4'd0) ? 4'd1 : ((wh_q > 4'd8) ? 4'd8 : wh_q);
    nin = (nin_q == 5'd0) ? 5'd1 : ((nin_q > 5'd16) ? 5'd16 : nin_q);
    nout = (nout_q == 5'd0) ? 5'd1 : ((nout_q > 5'd16) ? 5'd16 : nout_q);
  end

  // classify
  always_comb begin
    wr_w_o = acc_i && (operation_i == cfv_pkg::OpWeight) && pos_y_i < 6'd8 && pos_x_i < 6'd8;
    wr_b_o = acc_i && (operation_i == cfv_pkg::OpBias);
    wr_s_o = acc_i && (operation_i == cfv_pkg::OpSample);
    job_v_o = acc_i && (operation_i == cfv_pkg::OpCompute);
    job_o.bad = ({3'd0, ww} > iw) || ({3'd0, wh} > ih) || ({1'b0, out_map_i} >= nout)
             || ({1'b0, pos_x_i} > iw - {3'd0, ww}) || ({1'b0, pos_y_i} > ih - {3'd0, wh});
    job_o.om  = out_map_i;
    job_o.py  = pos_y_i;
    job_o.px  = pos_x_i;
    job_o.ww  = ww;
    job_o.wh  = wh;
    job_o.nin = nin;
  end
endmodule

/* rtl/cfv_queue.sv */
// short request queue between front and back
// depends on cfv_pkg
`timescale 1ns / 1ps
module cfv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfv_pkg::job_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cfv_pkg::job_t  data_o
);
  localparam int unsigned AW = $clog2(cfv_pkg::QDepth);
  cfv_pkg::job_t mem_q [cfv_pkg::QDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == AW'(0) + (AW+1)'(cfv_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

/* rtl/cfv_back.sv */
// back end: stores and multiply-accumulate sequencer
// depends on cfv_pkg
`timescale 1ns / 1ps
module cfv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_w_i,
  input  logic                wr_b_i,
  input  logic                wr_s_i,
  input  logic [3:0]          out_map_i,
  input  logic [3:0]          in_map_i,
  input  logic [5:0]          pos_y_i,
  input  logic [5:0]          pos_x_i,
  input  logic signed [31:0]  value_i,
  input  logic                empty_i,
  input  cfv_pkg::job_t       job_i,
  output logic                pop_o,
  output logic                idle_o,
  output logic                valid_o,
  output logic signed [31:0]  out_value_o,
  output logic                saturated_o,
  output logic                position_error_o
);
  localparam logic [2:0] SIdle = 3'd0, SRun = 3'd1, SDrain = 3'd2, SDone = 3'd5;
  logic signed [15:0] wmem [2**cfv_pkg::WAddrW];
  logic signed [15:0] smem [2**cfv_pkg::SAddrW];
  logic signed [31:0] bmem [cfv_pkg::MaxOutMaps];
  logic [2:0] st_q;
  cfv_pkg::job_t job_q;
  logic [3:0] i_q;
  logic [2:0] r_q, c_q;
  logic last_q, rd_v_q, mul_v_q, last_d1_q, last_d2_q;
  logic signed [15:0] wr_q, sr_q;
  logic signed [31:0] prod_q;
  logic signed [47:0] acc_q;
  logic last_pt;
  logic [5:0] sy, sx;

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_w_i) wmem[{out_map_i, in_map_i, pos_y_i[2:0], pos_x_i[2:0]}] <= cfv_pkg::sat16(value_i);
    if (wr_s_i) smem[{in_map_i, pos_y_i, pos_x_i}] <= cfv_pkg::sat16(value_i);
    if (wr_b_i) bmem[out_map_i] <= value_i;
    wr_q <= wmem[{job_q.om, i_q, r_q, c_q}];
    sr_q <= smem[{i_q, sy, sx}];
  end
  assign sy = job_q.py + {3'd0, r_q};
  assign sx = job_q.px + {3'd0, c_q};
  assign last_pt = ({1'b0, i_q} == job_q.nin - 1'b1) && ({1'b0, r_q} == job_q.wh - 1'b1)
                && ({1'b0, c_q} == job_q.ww - 1'b1);
  assign pop_o  = (st_q == SIdle) && !empty_i;
  assign idle_o = (st_q == SIdle);

  // sequencer: one window point a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; valid_o <= 1'b0; rd_v_q <= 1'b0; mul_v_q <= 1'b0;
      last_q <= 1'b0; last_d1_q <= 1'b0; last_d2_q <= 1'b0;
      i_q <= '0; r_q <= '0; c_q <= '0;
    end else begin
      valid_o <= 1'b0;
      rd_v_q <= (st_q == SRun);
      last_d1_q <= (st_q == SRun) && last_pt;
      mul_v_q <= rd_v_q;
      last_d2_q <= last_d1_q;
      unique case (st_q)
        SIdle: if (!empty_i) begin
          i_q <= '0; r_q <= '0; c_q <= '0;
          if (job_i.bad) begin
            valid_o <= 1'b1; out_value_o <= '0; saturated_o <= 1'b0;
            position_error_o <= 1'b1;
          end else st_q <= SRun;
        end
        SRun: begin
          if (last_pt) st_q <= SDrain;
          else if ({1'b0, c_q} != job_q.ww - 1'b1) c_q <= c_q + 1'b1;
          else begin
            c_q <= '0;
            if ({1'b0, r_q} != job_q.wh - 1'b1) r_q <= r_q + 1'b1;
            else begin r_q <= '0; i_q <= i_q + 1'b1; end
          end
        end
        SDrain: if (last_d2_q) st_q <= SDone;
        SDone: begin
          valid_o <= 1'b1; position_error_o <= 1'b0;
          if (acc_q > 48'sh00007fffffff) begin
            out_value_o <= 32'sh7fffffff; saturated_o <= 1'b1;
          end else if (acc_q < -48'sh000080000000) begin
            out_value_o <= 32'sh80000000; saturated_o <= 1'b1;
          end else begin
            out_value_o <= acc_q[31:0]; saturated_o <= 1'b0;
          end
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // job capture, multiply and accumulate
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      acc_q <= 48'(bmem[job_i.om]);
    end else if (mul_v_q) acc_q <= acc_q + 48'(prod_q);
    prod_q <= sr_q * wr_q;
  end
endmodule

/* rtl/conv_forward_valid.sv */
// top level of the valid-mode multichannel 2d convolution block
// depends on cfv_pkg, cfv_front, cfv_queue, cfv_back
`timescale 1ns / 1ps
// usage
// - command channel: an item is taken when start is high and busy is low;
//   operation selects weight, bias or sample write, or one output request
// - config channel: cfg_valid/cfg_ready with register index and data,
//   written by the user only while idle; the block does not enforce it
// - results: one beat per output request on the result ports, marked by
//   done_o for one cycle; the receiver cannot stall, none is held back
// - a request is queued by the front end and walked by the back end at
//   one multiply-accumulate per cycle
// - a good request passes the states SRun, SDrain and SDone, paced by the
//   single multiplier and the sample and weight memory ports; a bad
//   position is answered from SIdle without a walk
// - the back end pops a request only in SIdle, one request at a time
// - busy holds a write while any request is queued or running, and holds
//   a request while the queue is full
// - reset loads config register defaults and clears control; stores stay
//   undefined until written
module conv_forward_valid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          operation_i,
  input  logic [3:0]          out_map_i,
  input  logic [3:0]          in_map_i,
  input  logic [5:0]          pos_y_i,
  input  logic [5:0]          pos_x_i,
  input  logic signed [31:0]  value_i,
  output logic                done_o,
  output logic signed [31:0]  out_value_o,
  output logic                saturated_o,
  output logic                position_error_o
);
  logic acc, wr_w, wr_b, wr_s, job_v, full, empty, pop, idle;
  cfv_pkg::job_t job_in, job_out;

  // writes must not overtake requests still in flight
  assign busy = full || ((!empty || !idle) && (operation_i != cfv_pkg::OpCompute));
  assign acc  = start && !busy;

  cfv_front u_front (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .acc_i(acc), .operation_i, .out_map_i, .pos_y_i, .pos_x_i,
    .wr_w_o(wr_w), .wr_b_o(wr_b), .wr_s_o(wr_s),
    .job_v_o(job_v), .job_o(job_in)
  );

  cfv_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_v), .data_i(job_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(job_out)
  );

  cfv_back u_back (
    .clk_i, .rst_ni, .wr_w_i(wr_w), .wr_b_i(wr_b), .wr_s_i(wr_s),
    .out_map_i, .in_map_i, .pos_y_i, .pos_x_i, .value_i,
    .empty_i(empty), .job_i(job_out), .pop_o(pop), .idle_o(idle),
    .valid_o(done_o), .out_value_o, .saturated_o, .position_error_o
  );
endmodule

/* rtl/cfv_checker.sv */
// port-level checker for the convolution block, bound to the top level
// depends on conv_forward_valid_assert.svh and cfv_pkg
`timescale 1ns / 1ps
`include "conv_forward_valid_assert.svh"
module cfv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation_i,
  input logic        done_o,
  input logic [31:0] out_value_o,
  input logic        saturated_o,
  input logic        position_error_o
);
  // position error gives a zero value and no saturation
  `CFV_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && position_error_o, out_value_o == 32'd0 && !saturated_o)
  // saturated result sits at a rail
  `CFV_ASSERT_IMPL(a_sat_rail, clk_i, rst_ni, done_o && saturated_o, out_value_o == 32'h7fffffff || out_value_o == 32'h80000000)
  // a write item never produces a result in the next cycle on an empty block
  `CFV_ASSERT_NEXT(a_no_early, clk_i, rst_ni, start && !busy && operation_i != cfv_pkg::OpCompute, !done_o)
  // busy is never set straight out of reset
  `CFV_ASSERT_NEXT(a_busy_rst, clk_i, rst_ni, $rose(rst_ni), !busy)
endmodule

bind conv_forward_valid cfv_checker u_cfv_checker (
  .clk_i, .rst_ni, .start, .busy, .operation_i, .done_o, .out_value_o,
  .saturated_o, .position_error_o
);
